[rtl/hcd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hcd_pkg;

  localparam logic CMD_NODE = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] right;
    logic [7:0] value;
  } node_t;

  typedef struct packed {
    logic       leaf;
    logic       flush;
    logic [7:0] chr;
  } op_t;

endpackage

`default_nettype wire

[rtl/hcd_node_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module hcd_node_mem #(
  parameter int NODE_COUNT = 256
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [7:0]    wr_index,
  input  wire hcd_pkg::node_t wr_node,
  input  wire logic          rd_en,
  input  wire logic [7:0]    rd_index,
  output hcd_pkg::node_t     rd_node
);

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int XW = (AW > 8) ? AW : 8;

  hcd_pkg::node_t mem [NODE_COUNT];
  hcd_pkg::node_t rd_word;
  logic           rd_hit;
  logic [XW-1:0]  wr_ext;
  logic [XW-1:0]  rd_ext;
  logic           wr_in_range;
  logic           rd_in_range;

  assign wr_ext      = XW'(wr_index);
  assign rd_ext      = XW'(rd_index);
  assign wr_in_range = int'(wr_index) < NODE_COUNT;
  assign rd_in_range = int'(rd_index) < NODE_COUNT;

  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_ext[AW-1:0]] <= wr_node;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[rd_ext[AW-1:0]];
      rd_hit  <= rd_in_range;
    end
  end

  assign rd_node = rd_hit ? rd_word : '0;

endmodule

`default_nettype wire

[rtl/hcd_walker.sv]
`timescale 1ns / 1ps
`default_nettype none

module hcd_walker (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          cmd,
  input  wire logic [7:0]    data_byte,
  input  wire logic          first_of_message,
  input  wire logic [1:0]    start_phase,
  output logic               rd_en,
  output logic [7:0]         rd_index,
  input  wire hcd_pkg::node_t rd_node,
  output hcd_pkg::op_t       op,
  input  wire logic          op_ready
);

  localparam logic [2:0] TOP_BIT = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t     state, state_next;
  logic [7:0] current, current_next;
  logic       active, active_next;
  logic [2:0] bitpos, bitpos_next;
  logic       bits_left, bits_left_next;
  logic       step, step_next;
  logic [7:0] data, data_next;

  logic       accept;
  logic       leaf;
  logic [7:0] dest;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign leaf     = (rd_node.left == 8'd0) && (rd_node.right == 8'd0);
  assign dest     = data[bitpos] ? rd_node.right : rd_node.left;

  always_comb begin
    state_next     = state;
    current_next   = current;
    active_next    = active;
    bitpos_next    = bitpos;
    bits_left_next = bits_left;
    step_next      = step;
    data_next      = data;
    rd_en          = 1'b0;
    rd_index       = current;
    op             = '0;
    case (state)
      S_IDLE: begin
        if (accept && (cmd == hcd_pkg::CMD_DATA)) begin
          if (first_of_message) begin
            active_next  = 1'b1;
            current_next = 8'd0;
          end
          if (first_of_message || active) begin
            rd_en          = 1'b1;
            rd_index       = first_of_message ? 8'd0 : current;
            bitpos_next    = first_of_message ? (TOP_BIT - {start_phase, 1'b0}) : TOP_BIT;
            bits_left_next = 1'b1;
            step_next      = 1'b0;
            data_next      = data_byte;
            state_next     = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (step && leaf) begin
          op.leaf = 1'b1;
          op.chr  = rd_node.value;
          if (op_ready) begin
            current_next = 8'd0;
            if (rd_node.value == 8'd0) begin
              active_next = 1'b0;
              state_next  = S_FLUSH;
            end else if (!bits_left) begin
              state_next = S_FLUSH;
            end else begin
              rd_en     = 1'b1;
              rd_index  = 8'd0;
              step_next = 1'b0;
            end
          end
        end else if (!bits_left) begin
          state_next = S_FLUSH;
        end else begin
          rd_en        = 1'b1;
          rd_index     = dest;
          current_next = dest;
          step_next    = 1'b1;
          if (bitpos == 3'd0) begin
            bits_left_next = 1'b0;
          end else begin
            bitpos_next = bitpos - 3'd1;
          end
        end
      end
      S_FLUSH: begin
        op.flush = 1'b1;
        if (op_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      current <= 8'd0;
      active  <= 1'b0;
    end else begin
      state   <= state_next;
      current <= current_next;
      active  <= active_next;
    end
    bitpos    <= bitpos_next;
    bits_left <= bits_left_next;
    step      <= step_next;
    data      <= data_next;
  end

endmodule

`default_nettype wire

[rtl/hcd_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module hcd_out_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire hcd_pkg::op_t op,
  output logic            op_ready,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      character,
  output logic            end_of_text,
  output logic            last
);

  logic       pend_valid;
  logic [7:0] pend_char;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign op_ready = !pend_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if ((op.leaf || op.flush) && op_ready && pend_valid) begin
        out_valid   <= 1'b1;
        character   <= pend_char;
        end_of_text <= (pend_char == 8'd0);
        last        <= op.flush;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (op.leaf && op_ready) begin
        pend_valid <= 1'b1;
        pend_char  <= op.chr;
      end else if (op.flush && op_ready) begin
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/huffman_tree_text_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none

// Huffman tree-walk text decoder. A word with cmd 0 writes one node of the
// table; a word with cmd 1 is a data byte, walked bit by bit, most
// significant first, through one node-table read port. A data byte holds
// the input while it is walked and while the output is stalled: every bit
// walked is one dependent table read, and each character found before the
// last bit walked costs one more read to fetch the root again. A data byte
// that arrives while no message is open is ignored. Characters leave
// through a one-word holding stage so that the final one of a byte can
// carry last. Nodes must be loaded before a message walks through them.
module huffman_tree_text_decoder #(
  parameter int NODE_COUNT = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       cmd,
  input  wire logic [7:0] node_index,
  input  wire logic [7:0] left_child,
  input  wire logic [7:0] right_child,
  input  wire logic [7:0] leaf_value,
  input  wire logic [7:0] data_byte,
  input  wire logic       first_of_message,
  input  wire logic [1:0] start_phase,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      character,
  output logic            end_of_text,
  output logic            last
);

  hcd_pkg::node_t wr_node;
  hcd_pkg::node_t rd_node;
  hcd_pkg::op_t   op;
  logic           wr_en;
  logic           rd_en;
  logic [7:0]     rd_index;
  logic           op_ready;

  assign wr_en   = in_valid && !in_stall && (cmd == hcd_pkg::CMD_NODE);
  assign wr_node = '{left: left_child, right: right_child, value: leaf_value};

  hcd_node_mem #(
    .NODE_COUNT(NODE_COUNT)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_index (node_index),
    .wr_node  (wr_node),
    .rd_en    (rd_en),
    .rd_index (rd_index),
    .rd_node  (rd_node)
  );

  hcd_walker u_walker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .cmd              (cmd),
    .data_byte        (data_byte),
    .first_of_message (first_of_message),
    .start_phase      (start_phase),
    .rd_en            (rd_en),
    .rd_index         (rd_index),
    .rd_node          (rd_node),
    .op               (op),
    .op_ready         (op_ready)
  );

  hcd_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .op_ready    (op_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .character   (character),
    .end_of_text (end_of_text),
    .last        (last)
  );

endmodule

`default_nettype wire

[tb/huffman_tree_text_decoder_tb.sv]
`timescale 1ns / 1ps

module huffman_tree_text_decoder_tb;
  import hcd_pkg::*;

  localparam int MSB_BIT     = 7;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_LEN    = 300;
  localparam int DRAIN_WAIT  = 40;
  localparam int MAX_GAP     = 30;
  localparam int PHASE_WORDS = 57;
  localparam int PHASES      = 5;
  localparam int DIR_ROWS    = 25;

  typedef struct packed {
    logic       cmd;
    logic [7:0] idx;
    logic [7:0] lc;
    logic [7:0] rc;
    logic [7:0] val;
    logic [7:0] data;
    logic       first;
    logic [1:0] phase;
  } word_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       eot;
    logic       lst;
  } char_t;

  typedef struct packed {
    word_t      w;
    logic       typed;
    logic [3:0] n_chr;
    logic [7:0] chr;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{'{CMD_DATA, 8'd0,   8'd0,   8'd0, 8'h00, 8'hFF, 1'b0, 2'd3}, 1'b1, 4'd0, 8'h00},
    '{'{CMD_NODE, 8'd0,   8'd0,   8'd0, 8'h41, 8'h00, 1'b0, 2'd0}, 1'b1, 4'd0, 8'h00},
    '{'{CMD_DATA, 8'd0,   8'd0,   8'd0, 8'h00, 8'h00, 1'b1, 2'd0}, 1'b1, 4'd8, 8'h41},
    '{'{CMD_DATA, 8'd0,   8'd0,   8'd0, 8'h00, 8'hFF, 1'b0, 2'd0}, 1'b1, 4'd8, 8'h41},
    '{'{CMD_DATA, 8'd0,   8'd0,   8'd0, 8'h00, 8'h03, 1'b1, 2'd3}, 1'b1, 4'd2, 8'h41},
    '{'{CMD_DATA, 8'd0,   8'd0,   8'd0, 8'h00, 8'hA5, 1'b1, 2'd1}, 1'b1, 4'd6, 8'h41},
    '{'{CMD_DATA, 8'd0,   8'd0,   8'd0, 8'h00, 8'h5A, 1'b1, 2'd2}, 1'b1, 4'd4, 8'h41},
    '{'{CMD_NODE, 8'd0,   8'd0,   8'd0, 8'h00, 8'h00, 1'b0, 2'd0}, 1'b1, 4'd0, 8'h00},
    '{'{CMD_DATA, 8'd0,   8'd0,   8'd0, 8'h00, 8'hFF, 1'b1, 2'd0}, 1'b1, 4'd1, 8'h00},
    '{'{CMD_DATA, 8'd0,   8'd0,   8'd0, 8'h00, 8'hFF, 1'b0, 2'd0}, 1'b1, 4'd0, 8'h00},
    '{'{CMD_NODE, 8'd255, 8'd0,   8'd0, 8'hFF, 8'h00, 1'b0, 2'd0}, 1'b1, 4'd0, 8'h00},
    '{'{CMD_NODE, 8'd1,   8'd0,   8'd0, 8'h00, 8'h00, 1'b0, 2'd0}, 1'b1, 4'd0, 8'h00},
    '{'{CMD_NODE, 8'd2,   8'd0,   8'd0, 8'h80, 8'h00, 1'b0, 2'd0}, 1'b1, 4'd0, 8'h00},
    '{'{CMD_NODE, 8'd6,   8'd0,   8'd0, 8'h7E, 8'h00, 1'b0, 2'd0}, 1'b1, 4'd0, 8'h00},
    '{'{CMD_NODE, 8'd4,   8'd255, 8'd6, 8'h00, 8'h00, 1'b0, 2'd0}, 1'b1, 4'd0, 8'h00},
    '{'{CMD_NODE, 8'd3,   8'd2,   8'd4, 8'h55, 8'h00, 1'b0, 2'd0}, 1'b1, 4'd0, 8'h00},
    '{'{CMD_NODE, 8'd0,   8'd1,   8'd3, 8'hA5, 8'h00, 1'b0, 2'd0}, 1'b1, 4'd0, 8'h00},
    '{'{CMD_DATA, 8'd0,   8'd0,   8'd0, 8'h00, 8'hFF, 1'b1, 2'd0}, 1'b0, 4'd0, 8'h00},
    '{'{CMD_DATA, 8'd0,   8'd0,   8'd0, 8'h00, 8'hFF, 1'b0, 2'd3}, 1'b0, 4'd0, 8'h00},
    '{'{CMD_DATA, 8'd0,   8'd0,   8'd0, 8'h00, 8'h03, 1'b1, 2'd3}, 1'b1, 4'd0, 8'h00},
    '{'{CMD_NODE, 8'd255, 8'd0,   8'd0, 8'h11, 8'h00, 1'b0, 2'd0}, 1'b1, 4'd0, 8'h00},
    '{'{CMD_DATA, 8'd0,   8'd0,   8'd0, 8'h00, 8'h7F, 1'b0, 2'd0}, 1'b0, 4'd0, 8'h00},
    '{'{CMD_DATA, 8'd0,   8'd0,   8'd0, 8'h00, 8'hAA, 1'b0, 2'd1}, 1'b0, 4'd0, 8'h00},
    '{'{CMD_DATA, 8'd0,   8'd0,   8'd0, 8'h00, 8'h00, 1'b1, 2'd0}, 1'b1, 4'd1, 8'h00},
    '{'{CMD_DATA, 8'd0,   8'd0,   8'd0, 8'h00, 8'h10, 1'b0, 2'd2}, 1'b1, 4'd0, 8'h00}
  };

  localparam int SEND_TAB  [PHASES] = '{0, 66, 0, 10, 0};
  localparam int STALL_TAB [PHASES] = '{0, 0, 66, 10, 0};

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       cmd;
  logic [7:0] node_index;
  logic [7:0] left_child;
  logic [7:0] right_child;
  logic [7:0] leaf_value;
  logic [7:0] data_byte;
  logic       first_of_message;
  logic [1:0] start_phase;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] character;
  logic       end_of_text;
  logic       last;

  node_t      tree_mem [256];
  logic [7:0] walk_node;
  logic       msg_open;
  char_t      walk_out [8];
  char_t      pending_chars [$];
  char_t      head_c;

  logic       is_written [256];
  logic [7:0] written_list [$];

  int send_pct = 0;
  int stall_pct = 0;
  logic hold_on = 1'b0;
  int hold_cnt = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int chars_seen = 0;
  int words_live = 0;
  int node_words = 0;
  int data_words = 0;
  int trees_loaded = 0;

  huffman_tree_text_decoder u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .cmd              (cmd),
    .node_index       (node_index),
    .left_child       (left_child),
    .right_child      (right_child),
    .leaf_value       (leaf_value),
    .data_byte        (data_byte),
    .first_of_message (first_of_message),
    .start_phase      (start_phase),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .character        (character),
    .end_of_text      (end_of_text),
    .last             (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 100) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic int walk_tree(input word_t w);
    int         top;
    int         n;
    node_t      here;
    node_t      nxt;
    logic [7:0] dest;
    n = 0;
    top = MSB_BIT;
    if (w.cmd == CMD_NODE) begin
      tree_mem[w.idx] = '{left: w.lc, right: w.rc, value: w.val};
      return 0;
    end
    if (w.first) begin
      walk_node = 8'd0;
      msg_open = 1'b1;
      top = MSB_BIT - 2 * int'(w.phase);
    end
    if (!msg_open) return 0;
    for (int b = top; b >= 0; b--) begin
      here = tree_mem[walk_node];
      dest = w.data[b] ? here.right : here.left;
      nxt = tree_mem[dest];
      walk_node = dest;
      if (nxt.left == 8'd0 && nxt.right == 8'd0) begin
        walk_out[n] = '{chr: nxt.value, eot: nxt.value == 8'd0, lst: 1'b0};
        n++;
        walk_node = 8'd0;
        if (nxt.value == 8'd0) begin
          msg_open = 1'b0;
          break;
        end
      end
    end
    if (n > 0) walk_out[n - 1].lst = 1'b1;
    return n;
  endfunction

  function automatic word_t node_word(input logic [7:0] i, l, r, v);
    return '{cmd: CMD_NODE, idx: i, lc: l, rc: r, val: v, data: 8'($urandom),
             first: 1'($urandom), phase: 2'($urandom)};
  endfunction

  function automatic word_t data_word(input logic [7:0] d, input logic f, input logic [1:0] ph);
    return '{cmd: CMD_DATA, idx: 8'($urandom), lc: 8'($urandom), rc: 8'($urandom),
             val: 8'($urandom), data: d, first: f, phase: ph};
  endfunction

  function automatic logic [7:0] any_written();
    if ($urandom_range(3) == 0) return 8'd0;
    return written_list[$urandom_range(written_list.size() - 1)];
  endfunction

  // Call at a rising edge; returns at the edge that takes the word.
  task automatic put_word(input word_t w, input logic typed, input int n_typed,
                          input logic [7:0] typed_chr);
    int    gap;
    int    n;
    logic  live;
    char_t c;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd              <= w.cmd;
    node_index       <= w.idx;
    left_child       <= w.lc;
    right_child      <= w.rc;
    leaf_value       <= w.val;
    data_byte        <= w.data;
    first_of_message <= w.first;
    start_phase      <= w.phase;
    in_valid         <= 1'b1;
    live = w.cmd == CMD_NODE || w.first || msg_open;
    n = walk_tree(w);
    if (typed) n = n_typed;
    for (int i = 0; i < n; i++) begin
      if (typed) begin
        c.chr = typed_chr;
        c.eot = typed_chr == 8'd0;
        c.lst = i == n - 1;
      end else begin
        c = walk_out[i];
      end
      pending_chars.push_back(c);
    end
    if (w.cmd == CMD_NODE) begin
      node_words++;
      if (!is_written[w.idx]) begin
        is_written[w.idx] = 1'b1;
        written_list.push_back(w.idx);
      end
    end else if (live) begin
      data_words++;
    end
    words_live++;
    do @(posedge clk); while (in_stall);
  endtask

  always @(posedge clk) begin
    if (hold_on && hold_cnt < HOLD_LEN) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_stall <= $urandom_range(99) < stall_pct;
    end
    if (!hold_on) hold_cnt <= 0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("character %02h with none expected", character));
      end else begin
        head_c = pending_chars.pop_front();
        if (character !== head_c.chr)
          report_mismatch($sformatf("character %02h, expected %02h", character, head_c.chr));
        if (end_of_text !== head_c.eot)
          report_mismatch($sformatf("end_of_text %b, expected %b on character %02h",
                                    end_of_text, head_c.eot, head_c.chr));
        if (last !== head_c.lst)
          report_mismatch($sformatf("last %b, expected %b on character %02h",
                                    last, head_c.lst, head_c.chr));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d characters outstanding",
               IDLE_LIMIT, pending_chars.size());
      $display("huffman_tree_text_decoder_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    dir_row_t   row;
    logic [7:0] ids [255];
    logic [7:0] pool [$];
    logic [7:0] tmp;
    logic [7:0] ca;
    logic [7:0] cb;
    logic [7:0] parent;
    int         n_leaf;
    int         term;
    int         pick;
    int         nxt_id;
    int         n_more;
    int         base;

    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_NODE;
    node_index = 8'd0;
    left_child = 8'd0;
    right_child = 8'd0;
    leaf_value = 8'd0;
    data_byte = 8'd0;
    first_of_message = 1'b0;
    start_phase = 2'd0;
    walk_node = 8'd0;
    msg_open = 1'b0;
    foreach (tree_mem[i]) begin
      tree_mem[i] = '0;
      is_written[i] = 1'b0;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TABLE[i];
      put_word(row.w, row.typed, int'(row.n_chr), row.chr);
    end

    for (int p = 0; p < PHASES; p++) begin
      send_pct = SEND_TAB[p];
      stall_pct <= STALL_TAB[p];
      hold_on <= (p == PHASES - 1);
      base = words_live;
      while (words_live - base < PHASE_WORDS) begin
        if ($urandom_range(99) < 25) begin
          // load a fresh tree bottom up, leaves first and the root last
          n_leaf = $urandom_range(8, 2);
          for (int i = 0; i < 255; i++) ids[i] = 8'(i + 1);
          for (int i = 0; i < 2 * n_leaf - 2; i++) begin
            pick = $urandom_range(254, i);
            tmp = ids[i];
            ids[i] = ids[pick];
            ids[pick] = tmp;
          end
          if ($urandom_range(9) != 0) term = $urandom_range(n_leaf - 1);
          else term = -1;
          pool.delete();
          for (int i = 0; i < n_leaf; i++) begin
            put_word(node_word(ids[i], 8'd0, 8'd0,
                               (i == term) ? 8'd0 : 8'($urandom_range(255, 1))),
                     1'b0, 0, 8'd0);
            pool.push_back(ids[i]);
          end
          nxt_id = n_leaf;
          while (pool.size() > 1) begin
            pick = $urandom_range(pool.size() - 1);
            ca = pool[pick];
            pool.delete(pick);
            pick = $urandom_range(pool.size() - 1);
            cb = pool[pick];
            pool.delete(pick);
            if (pool.size() == 0) begin
              parent = 8'd0;
            end else begin
              parent = ids[nxt_id];
              nxt_id++;
            end
            put_word(node_word(parent, ca, cb, 8'($urandom)), 1'b0, 0, 8'd0);
            pool.push_back(parent);
          end
          trees_loaded++;
        end

        put_word(data_word(8'($urandom), 1'b1, 2'($urandom)), 1'b0, 0, 8'd0);
        n_more = $urandom_range(6);
        for (int k = 0; k < n_more; k++) begin
          if ($urandom_range(99) < 12) begin
            if ($urandom_range(1) == 0)
              put_word(node_word(8'($urandom), any_written(), any_written(), 8'($urandom)),
                       1'b0, 0, 8'd0);
            else
              put_word(data_word(8'($urandom), 1'b1, 2'($urandom)), 1'b0, 0, 8'd0);
          end
          put_word(data_word(8'($urandom), 1'b0, 2'($urandom)), 1'b0, 0, 8'd0);
        end
      end
    end
    in_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("walked %0d data bytes and %0d node writes (%0d random trees), %0d characters",
             data_words, node_words, trees_loaded, chars_seen);
    $display("flow: free running, sender gaps, output stalls, mixed, %0d-cycle output hold",
             HOLD_LEN);
    if (errors == 0 && pending_chars.size() == 0) begin
      $display("huffman_tree_text_decoder_tb OK");
    end else begin
      $display("huffman_tree_text_decoder_tb NOT OK");
    end
    $finish;
  end

endmodule

[huffman_tree_text_decoder.f]
rtl/hcd_pkg.sv
rtl/hcd_node_mem.sv
rtl/hcd_walker.sv
rtl/hcd_out_stage.sv
rtl/huffman_tree_text_decoder.sv
tb/huffman_tree_text_decoder_tb.sv
